// ===== design/clex_pkg.sv =====
package clex_pkg;

  localparam int unsigned LineLengthDef = 16;
  localparam int unsigned MaxStringDef  = 32;

  localparam int unsigned WaitW   = 28;
  localparam int unsigned NibIdxW = 4;

  // expander bits
  localparam logic [7:0] BitRs   = 8'h01;
  localparam logic [7:0] BitEn   = 8'h04;
  localparam logic [7:0] BitBl   = 8'h08;
  localparam logic [7:0] NibMask = 8'hF0;

  // lcd command bytes and characters
  localparam logic [7:0] CmdClear    = 8'h01;
  localparam logic [7:0] CmdSetAddr  = 8'h80;
  localparam logic [7:0] AddrLine1   = 8'h40;
  localparam logic [7:0] CharNul     = 8'h00;
  localparam logic [7:0] CharNewline = 8'h0A;

  // settle times per write of a nibble
  localparam logic [WaitW-1:0] WaitSetup  = 28'd50;
  localparam logic [WaitW-1:0] WaitEnPre  = 28'd150;
  localparam logic [WaitW-1:0] WaitEnHigh = 28'd80;
  localparam logic [WaitW-1:0] WaitHold   = 28'd270;
  localparam logic [WaitW-1:0] ExtraClear = 28'd500000;

  // power-up sequence as nibbles
  localparam logic [NibIdxW-1:0] InitNibbles = 4'd14;

  typedef enum logic [2:0] {
    ACT_INSTR     = 3'd0,
    ACT_DATA      = 3'd1,
    ACT_STRING    = 3'd2,
    ACT_POSITION  = 3'd3,
    ACT_BACKLIGHT = 3'd4,
    ACT_INIT      = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_NIBBLES,
    KIND_SINGLE
  } req_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_SINGLE
  } clex_state_e;

  typedef struct packed {
    logic               load;
    logic               emit_nib;
    logic               emit_one;
    logic [NibIdxW-1:0] idx;
    logic [1:0]         phase;
  } clex_cmd_t;

  typedef struct packed {
    req_kind_e          kind;
    logic [NibIdxW-1:0] nib_total;
    logic               out_free;
  } clex_stat_t;

  typedef struct packed {
    logic [7:0]       nib;
    logic [WaitW-1:0] extra;
  } nibble_t;

  function automatic nibble_t init_nibble(input logic [NibIdxW-1:0] idx);
    nibble_t r;
    r.nib   = 8'h00;
    r.extra = '0;
    case (idx)
      4'd0:  begin r.nib = 8'h30 | BitBl; r.extra = 28'd5000000;   end
      4'd1:  begin r.nib = 8'h30 | BitBl; r.extra = 28'd100000;    end
      4'd2:  begin r.nib = 8'h30 | BitBl; r.extra = 28'd100000;    end
      4'd3:  begin r.nib = 8'h20 | BitBl;                          end
      4'd4:  begin r.nib = 8'h28;                                  end
      4'd5:  begin r.nib = 8'h88;         r.extra = 28'd53000;     end
      4'd6:  begin r.nib = 8'h08;                                  end
      4'd7:  begin r.nib = 8'h88;         r.extra = 28'd53000;     end
      4'd8:  begin r.nib = 8'h08;                                  end
      4'd9:  begin r.nib = 8'h18;         r.extra = 28'd3500000;   end
      4'd10: begin r.nib = 8'h08;                                  end
      4'd11: begin r.nib = 8'h68;         r.extra = 28'd200000000; end
      4'd12: begin r.nib = 8'h08;                                  end
      4'd13: begin r.nib = 8'hC8;                                  end
      default: begin r.nib = 8'h00;                                end
    endcase
    return r;
  endfunction

endpackage

// ===== design/clex_ctrl.sv =====
module clex_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  clex_pkg::clex_stat_t  stat_i,
  output clex_pkg::clex_cmd_t   cmd_o
);
  import clex_pkg::*;

  clex_state_e        state_q, state_d;
  logic [NibIdxW-1:0] idx_q, idx_d;
  logic [1:0]         phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      phase_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    phase_d      = phase_q;
    cmd_o        = '0;
    cmd_o.idx    = idx_q;
    cmd_o.phase  = phase_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          idx_d      = '0;
          phase_d    = '0;
          case (stat_i.kind)
            KIND_NIBBLES: state_d = ST_RUN;
            KIND_SINGLE:  state_d = ST_SINGLE;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_RUN: begin
        if (stat_i.out_free) begin
          cmd_o.emit_nib = 1'b1;
          phase_d        = phase_q + 2'd1;
          if (phase_q == 2'd3) begin
            idx_d = idx_q + NibIdxW'(1);
            if (idx_q == stat_i.nib_total - NibIdxW'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      ST_SINGLE: begin
        if (stat_i.out_free) begin
          cmd_o.emit_one = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // a write is only loaded when the output register can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_nib || cmd_o.emit_one) |-> stat_i.out_free)
    else $error("write issued into a full output register");

  // nibble index stays inside the request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (idx_q < stat_i.nib_total))
    else $error("nibble index beyond request length");

  // a request that makes no word leaves the block idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> ((state_q == ST_IDLE) == ($past(stat_i.kind) == KIND_NONE)))
    else $error("controller state does not match request kind");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.emit_nib, cmd_o.emit_one}))
    else $error("conflicting datapath commands");

endmodule

// ===== design/clex_datapath.sv =====
module clex_datapath #(
  parameter int unsigned LINE_LENGTH = clex_pkg::LineLengthDef,
  parameter int unsigned MAX_STRING  = clex_pkg::MaxStringDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [2:0]                  action_i,
  input  logic [7:0]                  value_i,
  input  logic [4:0]                  column_i,
  input  logic [1:0]                  line_i,
  input  logic                        first_char_i,
  input  logic                        last_char_i,
  input  logic                        out_stall_i,
  input  clex_pkg::clex_cmd_t         cmd_i,
  output clex_pkg::clex_stat_t        stat_o,
  output logic                        out_valid_o,
  output logic [7:0]                  bus_byte_o,
  output logic                        write_valid_o,
  output logic [clex_pkg::WaitW-1:0]  wait_ns_o,
  output logic                        range_error_o,
  output logic                        last_o
);
  import clex_pkg::*;

  localparam int unsigned ColW   = $clog2(LINE_LENGTH + 1);
  localparam int unsigned TakenW = $clog2(MAX_STRING + 1);

  // string cursor state
  logic [ColW-1:0]   col_q, col_d, col_eff;
  logic [TakenW-1:0] taken_q, taken_d, taken_eff;
  logic              ended_q, ended_d, ended_eff;

  // request held for the controller
  logic [2:0][7:0]    byte_q, ld_byte;
  logic [2:0]         rs_q, ld_rs;
  logic               clr_q, ld_clr;
  logic               table_q, ld_table;
  logic [NibIdxW-1:0] total_q, ld_total;
  logic [7:0]         one_byte_q, ld_one_byte;
  logic               one_err_q, ld_one_err;

  logic [1:0] nbytes;
  logic       str_final, str_clear, str_wrap, str_char;
  req_kind_e  kind;

  // output register
  logic             out_valid_q;
  logic [7:0]       bus_q;
  logic             wv_q, err_q, last_q;
  logic [WaitW-1:0] wait_q;

  nibble_t          nib;
  logic [7:0]       cur_byte;
  logic [7:0]       w_byte;
  logic [WaitW-1:0] w_wait;
  logic             w_last;

  always_comb begin
    ld_byte     = '0;
    ld_rs       = '0;
    ld_clr      = 1'b0;
    ld_table    = 1'b0;
    ld_one_byte = '0;
    ld_one_err  = 1'b0;
    nbytes      = '0;
    kind        = KIND_NONE;
    str_final   = 1'b0;
    str_clear   = 1'b0;
    str_wrap    = 1'b0;
    str_char    = 1'b0;
    col_eff     = first_char_i ? '0 : col_q;
    taken_eff   = first_char_i ? '0 : taken_q;
    ended_eff   = first_char_i ? 1'b0 : ended_q;
    col_d       = col_q;
    taken_d     = taken_q;
    ended_d     = ended_q;

    case (action_e'(action_i))
      ACT_INSTR: begin
        ld_byte[0] = value_i;
        nbytes     = 2'd1;
      end
      ACT_DATA: begin
        ld_byte[0] = value_i;
        ld_rs[0]   = 1'b1;
        nbytes     = 2'd1;
      end
      ACT_POSITION: begin
        if (line_i > 2'd1 || 32'(column_i) >= LINE_LENGTH) begin
          ld_one_err = 1'b1;
          kind       = KIND_SINGLE;
        end else begin
          ld_byte[0] = CmdSetAddr | (line_i[0] ? (AddrLine1 + 8'(column_i)) : 8'(column_i));
          nbytes     = 2'd1;
        end
      end
      ACT_BACKLIGHT: begin
        ld_one_byte = value_i[0] ? BitBl : 8'h00;
        kind        = KIND_SINGLE;
      end
      ACT_INIT: begin
        ld_table = 1'b1;
        kind     = KIND_NIBBLES;
      end
      ACT_STRING: begin
        col_d   = col_eff;
        taken_d = taken_eff;
        ended_d = ended_eff;
        if (!ended_eff && taken_eff < TakenW'(MAX_STRING)) begin
          if (value_i == CharNul) begin
            ended_d = 1'b1;
          end else begin
            str_final = last_char_i || (taken_eff == TakenW'(MAX_STRING - 1));
            str_clear = first_char_i;
            if (str_final && value_i == CharNewline) begin
              // trailing newline is dropped
              ended_d = 1'b1;
            end else begin
              str_wrap = (col_eff >= ColW'(LINE_LENGTH));
              str_char = 1'b1;
              col_d    = (str_wrap ? '0 : col_eff) + ColW'(1);
              taken_d  = taken_eff + TakenW'(1);
              ended_d  = str_final;
            end
          end
        end
        // pack clear, wrap and character bytes in order
        if (str_clear) begin
          ld_byte[0] = CmdClear;
          ld_clr     = 1'b1;
          nbytes     = 2'd1;
        end
        if (str_wrap) begin
          ld_byte[nbytes] = CmdSetAddr | AddrLine1;
          nbytes          = nbytes + 2'd1;
        end
        if (str_char) begin
          ld_byte[nbytes] = value_i;
          ld_rs[nbytes]   = 1'b1;
          nbytes          = nbytes + 2'd1;
        end
      end
      default: ;
    endcase

    if (nbytes != 2'd0) begin
      kind = KIND_NIBBLES;
    end
    ld_total = ld_table ? InitNibbles : NibIdxW'({nbytes, 1'b0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      taken_q <= '0;
      ended_q <= 1'b0;
    end else if (cmd_i.load) begin
      col_q   <= col_d;
      taken_q <= taken_d;
      ended_q <= ended_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q     <= ld_byte;
      rs_q       <= ld_rs;
      clr_q      <= ld_clr;
      table_q    <= ld_table;
      total_q    <= ld_total;
      one_byte_q <= ld_one_byte;
      one_err_q  <= ld_one_err;
    end
  end

  // nibble for the current index, then the write for the current phase
  always_comb begin
    cur_byte = byte_q[cmd_i.idx[2:1]];
    if (table_q) begin
      nib = init_nibble(cmd_i.idx);
    end else begin
      nib.nib   = (cmd_i.idx[0] ? {cur_byte[3:0], 4'h0} : (cur_byte & NibMask))
                  | BitBl | (rs_q[cmd_i.idx[2:1]] ? BitRs : 8'h00);
      nib.extra = (cmd_i.idx[0] && clr_q && cmd_i.idx[2:1] == 2'd0) ? ExtraClear : '0;
    end
    case (cmd_i.phase)
      2'd0: begin w_byte = nib.nib;          w_wait = WaitSetup;            end
      2'd1: begin w_byte = BitEn;            w_wait = WaitEnPre;            end
      2'd2: begin w_byte = nib.nib | BitEn;  w_wait = WaitEnHigh;           end
      default: begin w_byte = nib.nib & ~BitEn; w_wait = WaitHold + nib.extra; end
    endcase
    w_last = (cmd_i.idx == total_q - NibIdxW'(1)) && (cmd_i.phase == 2'd3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_nib || cmd_i.emit_one) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_nib) begin
      bus_q  <= w_byte;
      wv_q   <= 1'b1;
      wait_q <= w_wait;
      err_q  <= 1'b0;
      last_q <= w_last;
    end else if (cmd_i.emit_one) begin
      bus_q  <= one_byte_q;
      wv_q   <= !one_err_q;
      wait_q <= '0;
      err_q  <= one_err_q;
      last_q <= 1'b1;
    end
  end

  assign stat_o.kind      = kind;
  assign stat_o.nib_total = total_q;
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign bus_byte_o    = bus_q;
  assign write_valid_o = wv_q;
  assign wait_ns_o     = wait_q;
  assign range_error_o = err_q;
  assign last_o        = last_q;

endmodule

// ===== design/char_lcd_expander_sequencer.sv =====
// Character LCD sequencer: each request word becomes a burst of byte writes for an
// I2C port expander driving an HD44780-style display in 4-bit mode (bit 0 register
// select, bit 2 enable, bit 3 backlight). Every nibble goes out as four writes, each
// with its settle time in wait_ns_o, and the final word of a request carries last_o.
// Once a request is taken, the controller loads one write per cycle into the output
// register while that register is empty or out_stall_i is low: instruction, data and
// position make eight writes, backlight and range errors one, string characters up
// to sixteen and the power-up sequence 56. A request that writes nothing (empty or
// ended string, unused action code) leaves the controller idle. The next request is
// accepted as soon as its predecessor's last word sits in the output register.
module char_lcd_expander_sequencer #(
  parameter int unsigned LINE_LENGTH = clex_pkg::LineLengthDef,
  parameter int unsigned MAX_STRING  = clex_pkg::MaxStringDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  action_i,
  input  logic [7:0]                  value_i,
  input  logic [4:0]                  column_i,
  input  logic [1:0]                  line_i,
  input  logic                        first_char_i,
  input  logic                        last_char_i,
  // expander write channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  bus_byte_o,
  output logic                        write_valid_o,
  output logic [clex_pkg::WaitW-1:0]  wait_ns_o,
  output logic                        range_error_o,
  output logic                        last_o
);
  import clex_pkg::*;

  clex_cmd_t  cmd;
  clex_stat_t stat;

  // controller: walks nibble index and write phase of the held request
  clex_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: request decode, string cursor, write generation, output register
  clex_datapath #(
    .LINE_LENGTH (LINE_LENGTH),
    .MAX_STRING  (MAX_STRING)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .action_i      (action_i),
    .value_i       (value_i),
    .column_i      (column_i),
    .line_i        (line_i),
    .first_char_i  (first_char_i),
    .last_char_i   (last_char_i),
    .out_stall_i   (out_stall_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .bus_byte_o    (bus_byte_o),
    .write_valid_o (write_valid_o),
    .wait_ns_o     (wait_ns_o),
    .range_error_o (range_error_o),
    .last_o        (last_o)
  );

endmodule
